// File: rtl/assert_macros.svh
// Assertion macros used by the formatter controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ITOA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("itoa: assertion failed");

// Antecedent in this cycle implies consequent in the next.
`define ITOA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("itoa: next-cycle assertion failed");

`endif

// File: rtl/itoa_pkg.sv
// Types, codes and character table for the integer-to-ASCII formatter.
`default_nettype none

package itoa_pkg;

    // Operand bits folded into the BCD register per conversion cycle.
    localparam int STEP_BITS = 8;

    // Mode codes: bit 1 selects hexadecimal (mode 3 behaves as mode 2).
    localparam logic [1:0] MODE_UDEC    = 2'd0;
    localparam logic [1:0] MODE_SDEC    = 2'd1;
    localparam logic [1:0] MODE_HEX     = 2'd2;
    localparam int         MODE_HEX_BIT = 1;

    typedef logic [3:0] t_digit;
    typedef logic [6:0] t_char;
    typedef logic [3:0] t_pos;

    localparam t_char CHAR_MINUS = 7'h2d;

    localparam t_char DIGIT_CHARS [16] = '{
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
    };

    function automatic t_char digit_char(input t_digit d);
        return DIGIT_CHARS[d];
    endfunction

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic conv_step;
        logic find;
        logic emit_sign;
        logic emit_digit;
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic in_hex;
        logic neg;
        logic ptr_zero;
    } t_dp_status;

endpackage

`default_nettype wire

// File: rtl/itoa_if.sv
// Valid/ready channel interfaces for operand requests and character requests.
`default_nettype none

interface itoa_in_if #(
    parameter int VALUE_WIDTH = 32
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] value;
    logic [1:0]             mode;

    modport source (output valid, output value, output mode, input ready);
    modport sink   (input valid, input value, input mode, output ready);
endinterface

interface itoa_out_if import itoa_pkg::*;;
    logic  valid;
    logic  ready;
    t_char character;
    t_pos  position;
    logic  last;

    modport source (output valid, output character, output position, output last,
                    input ready);
    modport sink   (input valid, input character, input position, input last,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/itoa_datapath.sv
// Datapath: magnitude, shift-add-3 BCD converter, digit register and output register.
`default_nettype none

module itoa_datapath import itoa_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  logic [1:0]             i_mode,
    input  t_dp_cmd                i_cmd,
    output t_dp_status             o_status,
    output t_char                  o_character,
    output t_pos                   o_position,
    output logic                   o_last
);

    localparam int STEPS   = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_W   = STEPS * STEP_BITS;
    localparam int DEC_DIG = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int HEX_DIG = (VALUE_WIDTH + 3) / 4;
    localparam int NDIG    = (DEC_DIG > HEX_DIG) ? DEC_DIG : HEX_DIG;
    localparam int PTR_W   = $clog2(NDIG);

    logic                       in_neg;
    logic [VALUE_WIDTH-1:0]     mag;

    logic [NDIG-1:0][3:0]       r_dig;
    logic [PAD_W-1:0]           r_bin;
    logic                       r_neg;
    logic [PTR_W-1:0]           r_ptr;
    t_pos                       r_pos;
    t_char                      r_char;
    t_pos                       r_opos;
    logic                       r_last;

    logic [NDIG-1:0][3:0]       conv_dig;
    logic [PAD_W-1:0]           conv_bin;
    logic [PTR_W-1:0]           lead;

    assign in_neg = (i_mode == MODE_SDEC) && i_value[VALUE_WIDTH-1];
    // Two's complement negate; the most negative value maps onto itself,
    // which read unsigned is exactly its magnitude.
    assign mag    = in_neg ? (~i_value + VALUE_WIDTH'(1)) : i_value;

    // STEP_BITS rounds of add-3 then shift.
    always_comb begin
        conv_dig = r_dig;
        conv_bin = r_bin;
        for (int s = 0; s < STEP_BITS; s++) begin
            for (int d = 0; d < NDIG; d++) begin
                if (conv_dig[d] >= 4'd5) begin
                    conv_dig[d] = conv_dig[d] + 4'd3;
                end
            end
            {conv_dig, conv_bin} = {conv_dig, conv_bin} << 1;
        end
    end

    // Most significant non-zero digit; zero if all digits are zero.
    always_comb begin
        lead = '0;
        for (int d = 0; d < NDIG; d++) begin
            if (r_dig[d] != 4'd0) begin
                lead = PTR_W'(d);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg <= in_neg;
            r_bin <= PAD_W'(mag);
            r_dig <= i_mode[MODE_HEX_BIT] ? (NDIG*4)'(mag) : '0;
        end
        if (i_cmd.conv_step) begin
            r_dig <= conv_dig;
            r_bin <= conv_bin;
        end
        if (i_cmd.find) begin
            r_ptr <= lead;
            r_pos <= '0;
        end
        if (i_cmd.emit_sign) begin
            r_char <= CHAR_MINUS;
            r_opos <= r_pos;
            r_last <= 1'b0;
            r_pos  <= r_pos + 1'b1;
        end
        if (i_cmd.emit_digit) begin
            r_char <= digit_char(r_dig[r_ptr]);
            r_opos <= r_pos;
            r_last <= (r_ptr == '0);
            r_pos  <= r_pos + 1'b1;
            if (r_ptr != '0) begin
                r_ptr <= r_ptr - 1'b1;
            end
        end
    end

    assign o_status.in_hex   = i_mode[MODE_HEX_BIT];
    assign o_status.neg      = r_neg;
    assign o_status.ptr_zero = (r_ptr == '0);

    assign o_character = r_char;
    assign o_position  = r_opos;
    assign o_last      = r_last;

endmodule

`default_nettype wire

// File: rtl/itoa_ctrl.sv
// Controller: sequences load, conversion, digit search and character output.
`default_nettype none

`include "assert_macros.svh"

module itoa_ctrl import itoa_pkg::*; #(
    parameter int STEPS = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CONV  = 3'd1;
    localparam logic [2:0] S_FIND  = 3'd2;
    localparam logic [2:0] S_SIGN  = 3'd3;
    localparam logic [2:0] S_DIGIT = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             slot_free;
    logic             accept;
    logic             in_conv;
    logic             conv_or_find;
    logic             last_emit;

    assign slot_free = !r_out_valid || i_out_ready;
    assign accept    = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = i_status.in_hex ? S_FIND : S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.conv_step = 1'b1;
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    n_state = S_FIND;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_FIND: begin
                o_cmd.find = 1'b1;
                n_state    = i_status.neg ? S_SIGN : S_DIGIT;
            end
            S_SIGN: begin
                if (slot_free) begin
                    o_cmd.emit_sign = 1'b1;
                    n_out_valid     = 1'b1;
                    n_state         = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (slot_free) begin
                    o_cmd.emit_digit = 1'b1;
                    n_out_valid      = 1'b1;
                    if (i_status.ptr_zero) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    assign in_conv      = (r_state == S_CONV);
    assign conv_or_find = in_conv || (r_state == S_FIND);
    assign last_emit    = (r_state == S_DIGIT) && slot_free && i_status.ptr_zero;

    `ITOA_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, accept, conv_or_find)
    `ITOA_ASSERT(a_cnt_range, i_clk, i_rst_n, in_conv |-> (r_cnt <= CNT_W'(STEPS - 1)))
    `ITOA_ASSERT_NEXT(a_last_emitted, i_clk, i_rst_n, last_emit, r_out_valid && o_in_ready)

endmodule

`default_nettype wire

// File: rtl/integer_to_ascii_formatter.sv
// Top level of the integer-to-ASCII formatter: controller plus datapath.
// Decimal: request taken, conversion steps of 8 bits per cycle through the shift-add-3
//   array, a leading-digit search, then one character per cycle while the receiver is ready.
// Hex: request taken, search, then one character per cycle while the receiver is ready.
// A new request is taken only after the last character of the previous one has been emitted.
// Synchronous active-low reset clears the controller and the output valid; no clearing pass.
`default_nettype none

module integer_to_ascii_formatter import itoa_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    itoa_in_if.sink     i_in,
    itoa_out_if.source  o_out
);

    // Conversion steps per decimal operand.
    localparam int STEPS = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;

    t_dp_cmd    cmd;
    t_dp_status status;

    // Controller: owns the state, conversion counter and output valid.
    itoa_ctrl #(
        .STEPS       (STEPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Datapath: negation, BCD conversion, digit pointer and the output register.
    // Characters leave most significant first; position counts from zero and
    // wraps at sixteen on very wide operands.
    itoa_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_value     (i_in.value),
        .i_mode      (i_in.mode),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_character (o_out.character),
        .o_position  (o_out.position),
        .o_last      (o_out.last)
    );

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench for the integer-to-ASCII formatter.
`timescale 1ns / 100ps

import itoa_pkg::*;

// One expected character request.
typedef struct packed {
    t_char character;
    t_pos  position;
    logic  last;
} t_text_char;

// Holds the characters still owed by the block and checks each one as it arrives.
class text_scoreboard;
    t_text_char owed_chars[$];
    int         errors;

    function new();
        errors = 0;
    endfunction

    // Work out the text of an accepted operand request and queue its characters.
    function void note_operand(logic [31:0] operand, logic [1:0] mode);
        logic [31:0] magnitude;
        int unsigned radix;
        int unsigned digit;
        t_char       digits[$];
        t_text_char  entry;
        bit          negative;
        int          total;
        int          n;

        radix     = mode[MODE_HEX_BIT] ? 16 : 10;
        negative  = (mode == MODE_SDEC) && operand[31];
        // 32'h8000_0000 negates to itself, which is exactly the magnitude wanted
        magnitude = negative ? -operand : operand;
        do begin
            digit = magnitude % radix;
            // '0'..'9' then 'a'..'f'
            digits.push_front(digit < 10 ? t_char'(7'h30 + digit) : t_char'(7'h61 + digit - 10));
            magnitude = magnitude / radix;
        end while (magnitude != 0);

        total = digits.size() + (negative ? 1 : 0);
        n = 0;
        if (negative) begin
            entry.character = CHAR_MINUS;
            entry.position  = t_pos'(n);
            entry.last      = (n == total - 1);
            owed_chars.push_back(entry);
            n++;
        end
        foreach (digits[k]) begin
            entry.character = digits[k];
            entry.position  = t_pos'(n);
            entry.last      = (n == total - 1);
            owed_chars.push_back(entry);
            n++;
        end
    endfunction

    function void check_char(t_char character, t_pos position, logic last);
        t_text_char want;
        if (owed_chars.size() == 0) begin
            $display("%0t: unexpected character request %h pos %0d last %0b",
                     $time, character, position, last);
            errors++;
            return;
        end
        want = owed_chars.pop_front();
        if (character !== want.character) begin
            $display("%0t: character mismatch: expected %h got %h",
                     $time, want.character, character);
            errors++;
        end
        if (position !== want.position) begin
            $display("%0t: position mismatch: expected %0d got %0d",
                     $time, want.position, position);
            errors++;
        end
        if (last !== want.last) begin
            $display("%0t: last flag mismatch: expected %0b got %0b",
                     $time, want.last, last);
            errors++;
        end
    endfunction

    function int pending();
        return owed_chars.size();
    endfunction
endclass

module tb_top;

    localparam int          VALUE_W       = 32;
    // Mode 3 has no name of its own in the package; bit 1 makes it hexadecimal.
    localparam logic [1:0]  MODE_HEX_ALT  = 2'd3;
    localparam int          IDLE_PERCENT  = 14;
    localparam int          RANDOM_ITEMS  = 140;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          DRAIN_CYCLES  = 30;

    logic i_clk;
    logic i_rst_n;

    itoa_in_if #(.VALUE_WIDTH(VALUE_W)) in_ch ();
    itoa_out_if                         out_ch ();

    integer_to_ascii_formatter #(
        .VALUE_WIDTH(VALUE_W)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    text_scoreboard ledger = new();

    // calm: both sides stop idling for a stretch, so the block runs flat out.
    // hold_asked / hold_done: the sender asks for one long receiver hold-off.
    bit calm;
    bit hold_asked;
    bit hold_done;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Generous cap on the run time, far above what a correct run needs.
    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Offer one operand request; returns once it has been taken.
    // Entered and left on a rising edge, so valid never gets two updates in a step.
    task automatic send_operand(input logic [31:0] operand, input logic [1:0] mode);
        if (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= operand;
        in_ch.mode  <= mode;
        do @(posedge i_clk); while (!in_ch.ready);
        ledger.note_operand(operand, mode);
    endtask

    // Receiver: random back-pressure, one long hold-off on request.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_asked && !hold_done) begin
                // sender keeps offering meanwhile, so the block must stall its input
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    // Character monitor: sampled before the edge's updates land.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            ledger.check_char(out_ch.character, out_ch.position, out_ch.last);
    end

    initial begin
        logic [31:0] operand;
        logic [1:0]  mode;

        calm       = 1'b0;
        hold_asked = 1'b0;
        hold_done  = 1'b0;
        i_rst_n     <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.value <= '0;
        in_ch.mode  <= MODE_UDEC;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero in every mode, extremes, the most negative signed value,
        // the unused mode, digit roll-overs.
        send_operand(32'h0000_0000, MODE_UDEC);
        send_operand(32'h0000_0000, MODE_SDEC);
        send_operand(32'h0000_0000, MODE_HEX);
        send_operand(32'h0000_0000, MODE_HEX_ALT);
        send_operand(32'hffff_ffff, MODE_UDEC);
        send_operand(32'hffff_ffff, MODE_SDEC);
        send_operand(32'hffff_ffff, MODE_HEX);
        send_operand(32'hffff_ffff, MODE_HEX_ALT);
        send_operand(32'h8000_0000, MODE_SDEC);
        send_operand(32'h8000_0000, MODE_UDEC);
        send_operand(32'h7fff_ffff, MODE_SDEC);
        send_operand(32'h0000_0001, MODE_SDEC);
        send_operand(32'h8000_0001, MODE_SDEC);
        send_operand(32'hdead_beef, MODE_HEX);
        send_operand(32'h0123_abcd, MODE_HEX_ALT);
        send_operand(32'd9,         MODE_UDEC);
        send_operand(32'd10,        MODE_UDEC);
        send_operand(32'h0000_000f, MODE_HEX);
        send_operand(32'h0000_0010, MODE_HEX);
        send_operand(32'd999999999, MODE_UDEC);
        send_operand(32'd1000000000, MODE_UDEC);
        send_operand(-32'sd10,      MODE_SDEC);

        // Random: mixed magnitudes so short and long runs both appear.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            case ($urandom_range(0, 5))
                0, 1: operand = $urandom;
                2:    operand = $urandom_range(0, 20);
                3:    operand = $urandom >> $urandom_range(0, 31);
                4:    operand = -$urandom_range(0, 20);
                default: begin
                    case ($urandom_range(0, 3))
                        0: operand = 32'h8000_0000;
                        1: operand = 32'h7fff_ffff;
                        2: operand = 32'hffff_ffff;
                        default: operand = 32'h0000_0000;
                    endcase
                end
            endcase
            mode = 2'($urandom_range(0, 3));
            if (i == 20)
                hold_asked = 1'b1;
            calm = (i >= 70) && (i < 110);
            send_operand(operand, mode);
        end
        calm = 1'b0;
        in_ch.valid <= 1'b0;

        while (ledger.pending() != 0) @(posedge i_clk);
        // let any stray characters show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (ledger.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
